// ===== rtl/gkd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gkd_pkg
// Shared types and constants of the grid key dedup counter.
// ----------------------------------------------------------------------------
package gkd_pkg;

  localparam int MAX_GRIDS    = 1024;
  localparam int HASH_BUCKETS = 4096;
  localparam int DIMS         = 4;
  localparam int COORD_W      = 16;
  localparam int ID_W         = 11;
  localparam int IDX_W        = $clog2(MAX_GRIDS);
  localparam int BKT_W        = $clog2(HASH_BUCKETS);
  localparam int CNT_W        = 20;
  localparam int DIMS_W       = 3;
  localparam int CMD_W        = 2;
  localparam int HASH_MULT    = 31;

  localparam logic [DIMS_W-1:0] DIMS_RESET = DIMS_W'(DIMS);
  localparam logic [CNT_W-1:0]  CNT_MAX    = {CNT_W{1'b1}};

  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_UNDEF = 2'd3;

  typedef logic [DIMS-1:0][COORD_W-1:0] key_t;

  typedef enum logic [3:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_HEAD,
    ST_HTAKE,
    ST_LOOK,
    ST_CMP,
    ST_GRID,
    ST_GTAKE,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic sweep;
    logic in_ready;
    logic take_head;
    logic step_next;
    logic hit;
    logic insert;
    logic full;
    logic rd_grid;
    logic take_grid;
    logic finish;
  } ctl_t;

  typedef struct packed {
    logic             in_valid;
    logic [CMD_W-1:0] in_cmd;
    logic             sweep_last;
    logic             cur_zero;
    logic             key_match;
    logic             gu_full;
    logic             out_free;
  } sts_t;

endpackage

// ===== rtl/gkd_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gkd_in_if
// Input channel: command, coordinates and grid select.
// ----------------------------------------------------------------------------
interface gkd_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic signed [15:0] coord_0;
  logic signed [15:0] coord_1;
  logic signed [15:0] coord_2;
  logic signed [15:0] coord_3;
  logic [10:0]        grid_sel;

  modport source (output valid, cmd, coord_0, coord_1, coord_2, coord_3, grid_sel,
                  input ready);
  modport sink (input valid, cmd, coord_0, coord_1, coord_2, coord_3, grid_sel,
                output ready);
endinterface

// ===== rtl/gkd_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gkd_out_if
// Output channel: one result item per command.
// ----------------------------------------------------------------------------
interface gkd_out_if;
  logic               valid;
  logic               ready;
  logic [10:0]        grid_id;
  logic               is_new;
  logic [19:0]        point_count;
  logic [10:0]        grid_total;
  logic               table_full;
  logic signed [15:0] out_coord_0;
  logic signed [15:0] out_coord_1;
  logic signed [15:0] out_coord_2;
  logic signed [15:0] out_coord_3;

  modport source (output valid, grid_id, is_new, point_count, grid_total, table_full,
                  out_coord_0, out_coord_1, out_coord_2, out_coord_3, input ready);
  modport sink (input valid, grid_id, is_new, point_count, grid_total, table_full,
                out_coord_0, out_coord_1, out_coord_2, out_coord_3, output ready);
endinterface

// ===== rtl/grid_key_dedup_counter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_key_dedup_counter
// Counts points per distinct grid key in a chained hash table.
// ----------------------------------------------------------------------------
// Usage:
//   in_if carries one command item (clear, add point, read grid) with
//   valid/ready; out_if returns exactly one result item per command.
//   cfg_we_i/cfg_data_i write dims_used; the user must do so only while the
//   block is idle, which the block leaves to the user. Items are handled one
//   at a time: a clear or unknown command goes straight to its result, a read
//   fetches one entry, an add walks its chain to a hit or inserts a new head.
//   The result sits in an output register, so the next item is accepted
//   while it waits; a stalled receiver holds the block in its final step
//   only once a second result is ready.
//   After reset the 4096-entry bucket memory is swept to empty, one entry
//   per cycle, and no item is accepted until the sweep is done; the grid
//   counter clears at once and dims_used returns to 4.
// ----------------------------------------------------------------------------
module grid_key_dedup_counter (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [gkd_pkg::DIMS_W-1:0] cfg_data_i,
  gkd_in_if.sink                     in_if,
  gkd_out_if.source                  out_if
);
  import gkd_pkg::*;

  logic [DIMS_W-1:0] dims_q;
  ctl_t              ctl;
  sts_t              sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q <= DIMS_RESET;
    end else if (cfg_we_i) begin
      dims_q <= cfg_data_i;
    end
  end

  gkd_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .ctl_o  (ctl)
  );

  gkd_dpath u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .dims_i (dims_q),
    .ctl_i  (ctl),
    .sts_o  (sts),
    .in_if  (in_if),
    .out_if (out_if)
  );

endmodule

// ===== rtl/gkd_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gkd_ctrl
// Sequencer for sweep, lookup, insert, read-back and result hand-off.
// ----------------------------------------------------------------------------
module gkd_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  gkd_pkg::sts_t sts_i,
  output gkd_pkg::ctl_t ctl_o
);
  import gkd_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SWEEP;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    unique case (state_q)
      ST_SWEEP: begin
        ctl_o.sweep = 1'b1;
        if (sts_i.sweep_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        ctl_o.in_ready = 1'b1;
        if (sts_i.in_valid) begin
          priority if (sts_i.in_cmd == CMD_CLEAR) state_d = ST_FIN;
          else if (sts_i.in_cmd == CMD_ADD) state_d = ST_HEAD;
          else if (sts_i.in_cmd == CMD_READ) state_d = ST_GRID;
          else state_d = ST_FIN;
        end
      end
      ST_HEAD:  state_d = ST_HTAKE;
      ST_HTAKE: begin
        ctl_o.take_head = 1'b1;
        state_d = ST_LOOK;
      end
      ST_LOOK: begin
        if (sts_i.cur_zero) begin
          if (sts_i.gu_full) ctl_o.full = 1'b1;
          else ctl_o.insert = 1'b1;
          state_d = ST_FIN;
        end else begin
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        if (sts_i.key_match) begin
          ctl_o.hit = 1'b1;
          state_d = ST_FIN;
        end else begin
          ctl_o.step_next = 1'b1;
          state_d = ST_LOOK;
        end
      end
      ST_GRID: begin
        ctl_o.rd_grid = 1'b1;
        state_d = ST_GTAKE;
      end
      ST_GTAKE: begin
        ctl_o.take_grid = 1'b1;
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (sts_i.out_free) begin
          ctl_o.finish = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/gkd_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gkd_dpath
// Hash, bucket and entry memories, grid counter and result registers.
// ----------------------------------------------------------------------------
module gkd_dpath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [gkd_pkg::DIMS_W-1:0] dims_i,
  input  gkd_pkg::ctl_t             ctl_i,
  output gkd_pkg::sts_t             sts_o,
  gkd_in_if.sink                    in_if,
  gkd_out_if.source                 out_if
);
  import gkd_pkg::*;

  localparam logic [BKT_W-1:0] M1 = BKT_W'(HASH_MULT);
  localparam logic [BKT_W-1:0] M2 = BKT_W'(HASH_MULT * HASH_MULT);
  localparam logic [BKT_W-1:0] M3 = BKT_W'(HASH_MULT * HASH_MULT * HASH_MULT);
  localparam logic [ID_W-1:0]  GRIDS_MAX = ID_W'(MAX_GRIDS);

  logic [ID_W-1:0]  heads [HASH_BUCKETS];
  logic [ID_W-1:0]  nxt_mem [MAX_GRIDS];
  key_t             key_mem [MAX_GRIDS];
  logic [CNT_W-1:0] cnt_mem [MAX_GRIDS];

  logic             accept;
  logic [DIMS_W-1:0] kd;
  key_t             key_in, key_q, key_rd_q;
  logic [BKT_W-1:0] bkt_d, bkt_q, sweep_q;
  logic [ID_W-1:0]  sel_q, gu_q, cur_q, head_val_q, head_rd_q, nxt_rd_q, head_chk;
  logic [CNT_W-1:0] cnt_rd_q, cnt_inc;
  logic [IDX_W-1:0] ent_ra, cur_idx;
  logic             heads_we;
  logic [BKT_W-1:0] heads_wa;
  logic [ID_W-1:0]  heads_wd;
  logic             sel_ok;

  logic [ID_W-1:0]  r_id_q;
  logic             r_new_q, r_full_q;
  logic [CNT_W-1:0] r_cnt_q;
  key_t             r_key_q;

  logic             ov_q;
  logic [ID_W-1:0]  o_id_q, o_tot_q;
  logic             o_new_q, o_full_q;
  logic [CNT_W-1:0] o_cnt_q;
  key_t             o_key_q;

  assign in_if.ready = ctl_i.in_ready;
  assign accept      = in_if.valid & ctl_i.in_ready;

  always_comb begin
    priority if (dims_i == '0) kd = DIMS_W'(1);
    else if (dims_i > DIMS_W'(DIMS)) kd = DIMS_W'(DIMS);
    else kd = dims_i;
    key_in[0] = in_if.coord_0;
    key_in[1] = in_if.coord_1;
    key_in[2] = in_if.coord_2;
    key_in[3] = in_if.coord_3;
    for (int d = 0; d < DIMS; d++) begin
      if (DIMS_W'(d) >= kd) key_in[d] = '0;
    end
    bkt_d = BKT_W'(key_in[0]) * M3 + BKT_W'(key_in[1]) * M2
          + BKT_W'(key_in[2]) * M1 + BKT_W'(key_in[3]);
  end

  assign head_chk = (head_rd_q > gu_q) ? '0 : head_rd_q;
  assign cur_idx  = IDX_W'(cur_q - ID_W'(1));
  assign ent_ra   = ctl_i.rd_grid ? IDX_W'(sel_q - ID_W'(1)) : cur_idx;
  assign cnt_inc  = (cnt_rd_q == CNT_MAX) ? cnt_rd_q : cnt_rd_q + CNT_W'(1);
  assign sel_ok   = (sel_q != '0) && (sel_q <= gu_q);

  assign heads_we = ctl_i.sweep | ctl_i.insert;
  assign heads_wa = ctl_i.sweep ? sweep_q : bkt_q;
  assign heads_wd = ctl_i.sweep ? '0 : gu_q + ID_W'(1);

  always_ff @(posedge clk_i) begin
    if (heads_we) heads[heads_wa] <= heads_wd;
    head_rd_q <= heads[bkt_q];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.insert) begin
      nxt_mem[IDX_W'(gu_q)] <= head_val_q;
      key_mem[IDX_W'(gu_q)] <= key_q;
    end
    if (ctl_i.insert) cnt_mem[IDX_W'(gu_q)] <= CNT_W'(1);
    else if (ctl_i.hit) cnt_mem[cur_idx] <= cnt_inc;
    nxt_rd_q <= nxt_mem[ent_ra];
    key_rd_q <= key_mem[ent_ra];
    cnt_rd_q <= cnt_mem[ent_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q <= '0;
      gu_q    <= '0;
      ov_q    <= 1'b0;
    end else begin
      if (ctl_i.sweep) sweep_q <= sweep_q + BKT_W'(1);
      if (accept && in_if.cmd == CMD_CLEAR) gu_q <= '0;
      else if (ctl_i.insert) gu_q <= gu_q + ID_W'(1);
      if (ctl_i.finish) ov_q <= 1'b1;
      else if (out_if.ready) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q    <= key_in;
      bkt_q    <= bkt_d;
      sel_q    <= in_if.grid_sel;
      r_id_q   <= '0;
      r_new_q  <= 1'b0;
      r_full_q <= 1'b0;
      r_cnt_q  <= '0;
      r_key_q  <= '0;
    end
    if (ctl_i.take_head) begin
      cur_q      <= head_chk;
      head_val_q <= head_chk;
    end
    if (ctl_i.step_next) cur_q <= nxt_rd_q;
    if (ctl_i.hit) begin
      r_id_q  <= cur_q;
      r_cnt_q <= cnt_inc;
    end
    if (ctl_i.insert) begin
      r_id_q  <= gu_q + ID_W'(1);
      r_new_q <= 1'b1;
      r_cnt_q <= CNT_W'(1);
    end
    if (ctl_i.full) r_full_q <= 1'b1;
    if (ctl_i.take_grid && sel_ok) begin
      r_id_q  <= sel_q;
      r_cnt_q <= cnt_rd_q;
      r_key_q <= key_rd_q;
    end
    if (ctl_i.finish) begin
      o_id_q   <= r_id_q;
      o_new_q  <= r_new_q;
      o_cnt_q  <= r_cnt_q;
      o_full_q <= r_full_q;
      o_key_q  <= r_key_q;
      o_tot_q  <= gu_q;
    end
  end

  assign sts_o.in_valid   = in_if.valid;
  assign sts_o.in_cmd     = in_if.cmd;
  assign sts_o.sweep_last = (sweep_q == {BKT_W{1'b1}});
  assign sts_o.cur_zero   = (cur_q == '0);
  assign sts_o.key_match  = (key_rd_q == key_q);
  assign sts_o.gu_full    = (gu_q == GRIDS_MAX);
  assign sts_o.out_free   = !ov_q || out_if.ready;

  assign out_if.valid       = ov_q;
  assign out_if.grid_id     = o_id_q;
  assign out_if.is_new      = o_new_q;
  assign out_if.point_count = o_cnt_q;
  assign out_if.grid_total  = o_tot_q;
  assign out_if.table_full  = o_full_q;
  assign out_if.out_coord_0 = o_key_q[0];
  assign out_if.out_coord_1 = o_key_q[1];
  assign out_if.out_coord_2 = o_key_q[2];
  assign out_if.out_coord_3 = o_key_q[3];

endmodule

// ===== tb/sv/tb_grid_key_dedup_counter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_grid_key_dedup_counter
// Randomized self-checking bench for the grid key dedup counter. A
// scoreboard keeps its own hash table of grid keys, predicts one result per
// command and compares it with the block's output. Stimulus covers directed
// corner items, phases with different key widths and idling patterns, and
// a closing pass of reads, clears and random items.
// ----------------------------------------------------------------------------
module tb_grid_key_dedup_counter;
  import gkd_pkg::*;

  typedef struct packed {
    logic [ID_W-1:0]    grid_id;
    logic               is_new;
    logic [CNT_W-1:0]   point_count;
    logic [ID_W-1:0]    grid_total;
    logic               table_full;
    logic [COORD_W-1:0] oc0;
    logic [COORD_W-1:0] oc1;
    logic [COORD_W-1:0] oc2;
    logic [COORD_W-1:0] oc3;
  } grid_result_t;

  class grid_table_sb;
    int unsigned        heads[HASH_BUCKETS];
    int unsigned        next_id[MAX_GRIDS];
    key_t               keys[MAX_GRIDS];
    logic [CNT_W-1:0]   counts[MAX_GRIDS];
    int unsigned        used;
    logic [DIMS_W-1:0]  dims;
    grid_result_t       expected_q[$];
    int                 errors;
    int                 n_new, n_hit, n_full, n_read, n_clear;

    function void reset_state();
      foreach (heads[i]) heads[i] = 0;
      used = 0;
      dims = DIMS_RESET;
    endfunction

    function void note(logic [CMD_W-1:0] cmd, key_t coords, logic [ID_W-1:0] sel);
      grid_result_t r;
      key_t         k;
      int unsigned  kd, id;
      logic [31:0]  h;
      r = '0;
      if (cmd == CMD_CLEAR) begin
        foreach (heads[i]) heads[i] = 0;
        used = 0;
        n_clear++;
      end else if (cmd == CMD_ADD) begin
        kd = (dims == 0) ? 1 : ((dims > DIMS) ? DIMS : dims);
        h = 0;
        for (int d = 0; d < DIMS; d++) begin
          k[d] = (d < kd) ? coords[d] : '0;
          h = h * HASH_MULT + 32'(k[d]);
        end
        id = heads[h % HASH_BUCKETS];
        while (id != 0 && keys[id-1] != k) id = next_id[id-1];
        if (id != 0) begin
          if (counts[id-1] != CNT_MAX) counts[id-1]++;
          r.grid_id = ID_W'(id);
          r.point_count = counts[id-1];
          n_hit++;
        end else if (used < MAX_GRIDS) begin
          id = used + 1;
          keys[id-1] = k;
          counts[id-1] = CNT_W'(1);
          next_id[id-1] = heads[h % HASH_BUCKETS];
          heads[h % HASH_BUCKETS] = id;
          used = id;
          r.grid_id = ID_W'(id);
          r.is_new = 1'b1;
          r.point_count = CNT_W'(1);
          n_new++;
        end else begin
          r.table_full = 1'b1;
          n_full++;
        end
      end else if (cmd == CMD_READ) begin
        n_read++;
        if (sel >= 1 && sel <= used) begin
          r.grid_id = sel;
          r.point_count = counts[sel-1];
          r.oc0 = keys[sel-1][0];
          r.oc1 = keys[sel-1][1];
          r.oc2 = keys[sel-1][2];
          r.oc3 = keys[sel-1][3];
        end
      end
      r.grid_total = ID_W'(used);
      expected_q.push_back(r);
    endfunction

    function void check(grid_result_t got);
      grid_result_t exp;
      if (expected_q.size() == 0) begin
        $display("%0t unexpected result %p", $time, got);
        errors++;
        return;
      end
      exp = expected_q.pop_front();
      if (got.grid_id !== exp.grid_id || got.is_new !== exp.is_new ||
          got.point_count !== exp.point_count || got.grid_total !== exp.grid_total ||
          got.table_full !== exp.table_full || got.oc0 !== exp.oc0 ||
          got.oc1 !== exp.oc1 || got.oc2 !== exp.oc2 || got.oc3 !== exp.oc3) begin
        $display("%0t mismatch expected %p actual %p", $time, exp, got);
        errors++;
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we;
  logic [DIMS_W-1:0] cfg_data;
  int                send_idle_pct;
  int                recv_stall_pct;
  grid_table_sb      sb;

  gkd_in_if  in_if ();
  gkd_out_if out_if ();

  grid_key_dedup_counter i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data),
    .in_if      (in_if),
    .out_if     (out_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      sb.check({out_if.grid_id, out_if.is_new, out_if.point_count, out_if.grid_total,
                out_if.table_full, out_if.out_coord_0, out_if.out_coord_1,
                out_if.out_coord_2, out_if.out_coord_3});
    end
  end

  task automatic push(logic [CMD_W-1:0] cmd, key_t c, logic [ID_W-1:0] sel);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid    <= 1'b1;
    in_if.cmd      <= cmd;
    in_if.coord_0  <= c[0];
    in_if.coord_1  <= c[1];
    in_if.coord_2  <= c[2];
    in_if.coord_3  <= c[3];
    in_if.grid_sel <= sel;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note(cmd, c, sel);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_dims(logic [DIMS_W-1:0] v);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    sb.dims = v;
  endtask

  function automatic key_t rand_key(bit narrow);
    key_t k;
    for (int d = 0; d < DIMS; d++)
      k[d] = narrow ? COORD_W'($urandom_range(6) - 3) : COORD_W'($urandom);
    return k;
  endfunction

  task automatic random_item();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 60) push(CMD_ADD, rand_key($urandom_range(99) < 70), '0);
    else if (p < 85) push(CMD_READ, rand_key(0), ID_W'($urandom_range(sb.used + 2)));
    else if (p < 93) push(CMD_READ, rand_key(0), ID_W'($urandom));
    else if (p < 97) push(CMD_UNDEF, rand_key(0), ID_W'($urandom));
    else push(CMD_CLEAR, rand_key(0), ID_W'($urandom));
  endtask

  initial begin
    key_t k;
    sb = new();
    sb.reset_state();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst_ni         = 1'b0;
    cfg_we         = 1'b0;
    cfg_data       = '0;
    in_if.valid    = 1'b0;
    in_if.cmd      = CMD_CLEAR;
    in_if.coord_0  = '0;
    in_if.coord_1  = '0;
    in_if.coord_2  = '0;
    in_if.coord_3  = '0;
    in_if.grid_sel = '0;
    out_if.ready   = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed corners
    k = {16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF};
    push(CMD_ADD, k, '0);
    push(CMD_ADD, k, '0);
    push(CMD_ADD, {16'sh7FFF, 16'sh8000, 16'shFFFF, 16'sh0000}, '0);
    push(CMD_ADD, '0, '0);
    push(CMD_ADD, '1, '0);
    push(CMD_READ, '0, 11'd1);
    push(CMD_READ, '0, 11'd4);
    push(CMD_READ, '0, 11'd0);
    push(CMD_READ, '0, 11'd5);
    push(CMD_READ, '1, 11'h7FF);
    push(CMD_UNDEF, '1, 11'd1);
    push(CMD_CLEAR, '1, '1);
    push(CMD_READ, '0, 11'd1);
    push(CMD_ADD, k, '0);
    set_dims(3'd0);
    push(CMD_ADD, {16'sh0001, 16'sh1234, 16'sh0000, 16'sh0005}, '0);
    push(CMD_ADD, {16'sh0001, 16'sh4321, 16'sh7777, 16'sh0009}, '0);
    push(CMD_READ, '0, 11'd2);
    set_dims(3'd7);
    push(CMD_ADD, k, '0);
    push(CMD_ADD, k, '0);

    // random phases over key widths and idling patterns
    for (int ph = 0; ph < 8; ph++) begin
      set_dims(DIMS_W'(ph == 0 ? 1 : (ph == 1 ? 4 : $urandom_range(7))));
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      for (int i = 0; i < 60; i++) begin
        random_item();
        if (i == 30) drain();
      end
    end

    // read back over the whole id range, then clear and run on
    set_dims(3'd4);
    send_idle_pct  = 7;
    recv_stall_pct = 7;
    for (int i = 0; i < 20; i++) push(CMD_READ, '0, ID_W'($urandom_range(MAX_GRIDS + 1)));
    push(CMD_READ, '0, 11'd1024);
    push(CMD_CLEAR, '0, '0);
    for (int i = 0; i < 30; i++) random_item();

    drain();
    $display("covered %0d new grids, %0d hits, %0d full rejects", sb.n_new, sb.n_hit,
             sb.n_full);
    $display("plus %0d reads and %0d clears", sb.n_read, sb.n_clear);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== grid_key_dedup_counter.f =====
rtl/gkd_pkg.sv
rtl/gkd_in_if.sv
rtl/gkd_out_if.sv
rtl/gkd_ctrl.sv
rtl/gkd_dpath.sv
rtl/grid_key_dedup_counter.sv
tb/sv/tb_grid_key_dedup_counter.sv
